@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ hdl/tccs_pkg.sv @@
// Package: screen geometry, widths, codes, state and control types.
package tccs_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CUR_W   = $clog2(CELLS + 1);
    localparam int ROW_W   = $clog2(ROWS + 1);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = CHAR_W + ATTR_W;
    localparam int RADDR_W = 11;
    localparam int POS_W   = 11;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_DRAIN,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic newline;
        logic advance;
        logic home_last;
    } t_cur_cmd;

    typedef struct packed {
        logic [CUR_W-1:0] lin;
        logic             at_bottom;
        logic             full;
    } t_cur_stat;

endpackage

@@ hdl/tccs_if.sv @@
// Channel interfaces: request (put/read) and response.
interface tccs_req_if;
    import tccs_pkg::*;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [CHAR_W-1:0]   character;
    logic [ATTR_W-1:0]   attribute;
    logic [RADDR_W-1:0]  read_address;
    modport source (output valid, operation, character, attribute, read_address,
                    input ready);
    modport sink   (input valid, operation, character, attribute, read_address,
                    output ready);
endinterface

interface tccs_rsp_if;
    import tccs_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] read_character;
    logic [ATTR_W-1:0] read_attribute;
    logic [POS_W-1:0]  cursor_position;
    logic              scrolled;
    modport source (output valid, read_character, read_attribute, cursor_position,
                    scrolled, input ready);
    modport sink   (input valid, read_character, read_attribute, cursor_position,
                    scrolled, output ready);
endinterface

@@ hdl/text_console_cursor_scroll_unit.sv @@
// Top level: text console with cursor, cell store and scroll engine.
//
//  channel  | dir | transfer when           | payload
//  ---------+-----+-------------------------+----------------------------------------
//  i_req    | in  | i_req.valid & ready     | operation, character, attribute, address
//  o_rsp    | out | o_rsp.valid & ready     | read char/attr, cursor_position, scrolled
//
//  The finish state holds for as long as the previous result still waits
//  unaccepted in the output register. A scroll moves the cell RAM one
//  cell per cycle through its single write port (read row below, write back).
//  After reset the RAM is cleared one cell a cycle; i_req.ready is low
//  while it clears.
//  A new request is taken while a finished result waits on o_rsp.
module text_console_cursor_scroll_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tccs_req_if.sink    i_req,
    tccs_rsp_if.source  o_rsp
);
    import tccs_pkg::*;

    localparam int CMP_W = ((ADDR_W + 1) > RADDR_W) ? (ADDR_W + 1) : (RADDR_W + 1);
    localparam int EXT_W = (CUR_W > POS_W) ? CUR_W : POS_W;

    t_state r_state, n_state;

    // latched item
    logic [CHAR_W-1:0] r_char, n_char;
    logic [ATTR_W-1:0] r_attr, n_attr;
    logic              r_pend_put, n_pend_put;
    logic              r_rd_ok, n_rd_ok;

    // sweep counter (clear and scroll) and the delayed scroll write
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic              r_wv, n_wv;
    logic [ADDR_W-1:0] r_wa, n_wa;
    logic              r_wz, n_wz;

    // result being built
    logic [CHAR_W-1:0] r_res_char, n_res_char;
    logic [ATTR_W-1:0] r_res_attr, n_res_attr;
    logic              r_res_scr, n_res_scr;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic [ATTR_W-1:0] r_out_attr, n_out_attr;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;
    logic              r_out_scr, n_out_scr;

    logic              accept;
    logic              is_read;
    logic              is_newline;
    logic              sweep_last;
    logic              out_load;
    logic [CMP_W-1:0]  addr_ext;
    logic              addr_ok;
    logic [EXT_W-1:0]  cur_ext;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    t_cur_cmd          cur_cmd;
    t_cur_stat         cur_stat;

    assign accept     = (r_state == S_IDLE) && i_req.valid;
    assign is_read    = (i_req.operation == OP_READ);
    assign is_newline = (i_req.character == NEWLINE_CODE);
    assign sweep_last = (r_cnt == ADDR_W'(CELLS - 1));
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign addr_ext   = CMP_W'(i_req.read_address);
    assign addr_ok    = (addr_ext < CMP_W'(CELLS));
    assign cur_ext    = EXT_W'(cur_stat.lin);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (sweep_last) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (is_read) begin
                        n_state = S_READ;
                    end else if (is_newline) begin
                        n_state = cur_stat.at_bottom ? S_SCROLL : S_DONE;
                    end else begin
                        n_state = cur_stat.full ? S_SCROLL : S_PUT;
                    end
                end
            end
            S_READ:   n_state = S_DONE;
            S_SCROLL: if (sweep_last) n_state = S_DRAIN;
            S_DRAIN:  n_state = r_pend_put ? S_PUT : S_DONE;
            S_PUT:    n_state = S_DONE;
            S_DONE:   if (out_load) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // control outputs: handshake, RAM ports, cursor commands
    always_comb begin
        i_req.ready       = (r_state == S_IDLE);
        cur_cmd.newline   = accept && !is_read && is_newline && !cur_stat.at_bottom;
        cur_cmd.home_last = (r_state == S_DRAIN);
        cur_cmd.advance   = (r_state == S_PUT);

        ram_re    = 1'b0;
        ram_raddr = addr_ext[ADDR_W-1:0];
        if (r_state == S_SCROLL) begin
            // fetch the cell one row below; rows past the last are zero-filled
            ram_re    = (r_cnt < ADDR_W'(CELLS - COLUMNS));
            ram_raddr = r_cnt + ADDR_W'(COLUMNS);
        end else if (accept && is_read && addr_ok) begin
            ram_re    = 1'b1;
        end

        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = r_wz ? '0 : ram_rdata;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt;
            ram_wdata = '0;
        end else if (r_wv) begin
            ram_we    = 1'b1;
        end else if (r_state == S_PUT) begin
            ram_we    = 1'b1;
            ram_waddr = cur_stat.lin[ADDR_W-1:0];
            ram_wdata = {r_attr, r_char};
        end
    end

    // datapath next values
    always_comb begin
        n_char     = r_char;
        n_attr     = r_attr;
        n_pend_put = r_pend_put;
        n_rd_ok    = r_rd_ok;
        n_res_char = r_res_char;
        n_res_attr = r_res_attr;
        n_res_scr  = r_res_scr;

        if (accept) begin
            n_char     = i_req.character;
            n_attr     = i_req.attribute;
            n_pend_put = !is_read && !is_newline;
            n_rd_ok    = addr_ok;
            n_res_char = '0;
            n_res_attr = '0;
            n_res_scr  = !is_read && (is_newline ? cur_stat.at_bottom : cur_stat.full);
        end
        if (r_state == S_READ && r_rd_ok) begin
            n_res_char = ram_rdata[CHAR_W-1:0];
            n_res_attr = ram_rdata[CELL_W-1:CHAR_W];
        end

        if ((r_state == S_CLEAR || r_state == S_SCROLL) && !sweep_last) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = '0;
        end
        n_wv = (r_state == S_SCROLL);
        n_wa = r_cnt;
        n_wz = (r_cnt >= ADDR_W'(CELLS - COLUMNS));

        n_out_valid = out_load || (r_out_valid && !o_rsp.ready);
        n_out_char  = r_out_char;
        n_out_attr  = r_out_attr;
        n_out_pos   = r_out_pos;
        n_out_scr   = r_out_scr;
        if (out_load) begin
            n_out_char = r_res_char;
            n_out_attr = r_res_attr;
            n_out_pos  = cur_ext[POS_W-1:0];
            n_out_scr  = r_res_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend_put  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wv        <= n_wv;
            r_out_valid <= n_out_valid;
            r_pend_put  <= n_pend_put;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_attr     <= n_attr;
        r_rd_ok    <= n_rd_ok;
        r_res_char <= n_res_char;
        r_res_attr <= n_res_attr;
        r_res_scr  <= n_res_scr;
        r_wa       <= n_wa;
        r_wz       <= n_wz;
        r_out_char <= n_out_char;
        r_out_attr <= n_out_attr;
        r_out_pos  <= n_out_pos;
        r_out_scr  <= n_out_scr;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.read_character  = r_out_char;
    assign o_rsp.read_attribute  = r_out_attr;
    assign o_rsp.cursor_position = r_out_pos;
    assign o_rsp.scrolled        = r_out_scr;

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tccs_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cur_cmd),
        .o_stat  (cur_stat)
    );
endmodule

@@ hdl/tccs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/tccs_cursor.sv @@
// Cursor registers: row, column and linear cell index kept in step.
module tccs_cursor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tccs_pkg::t_cur_cmd   i_cmd,
    output tccs_pkg::t_cur_stat  o_stat
);
    import tccs_pkg::*;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [CUR_W-1:0] r_lin, n_lin;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_lin = r_lin;
        if (i_cmd.home_last) begin
            n_row = ROW_W'(ROWS - 1);
            n_col = '0;
            n_lin = CUR_W'(CELLS - COLUMNS);
        end else if (i_cmd.newline) begin
            // start of next row: add what is left of this row
            n_row = r_row + 1'b1;
            n_col = '0;
            n_lin = r_lin + CUR_W'(COLUMNS) - CUR_W'(r_col);
        end else if (i_cmd.advance) begin
            if (r_col == COL_W'(COLUMNS - 1)) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
            n_lin = r_lin + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_lin <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_lin <= n_lin;
        end
    end

    // a cursor past the last cell sits on row ROWS and counts as bottom
    assign o_stat.lin       = r_lin;
    assign o_stat.at_bottom = (r_row >= ROW_W'(ROWS - 1));
    assign o_stat.full      = (r_lin >= CUR_W'(CELLS));
endmodule

@@ hdl/tccs_checker.sv @@
// Port-level checker for the console, bound to the top level.
`include "assert_macros.svh"

module tccs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [tccs_pkg::CHAR_W-1:0]  i_rsp_read_character,
    input logic [tccs_pkg::ATTR_W-1:0]  i_rsp_read_attribute,
    input logic [tccs_pkg::POS_W-1:0]   i_rsp_cursor_position,
    input logic                         i_rsp_scrolled
);
    import tccs_pkg::*;

    localparam logic [POS_W-1:0] LAST_ROW = POS_W'(CELLS - COLUMNS);

    // store is being cleared right after reset: no request taken
    `ASSERT_CLK_ALWAYS(a_no_req_after_rst, i_clk, !i_rst_n |=> !i_req_ready, "request taken during clear")

    `ASSERT_CLK(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable({i_rsp_read_character, i_rsp_read_attribute, i_rsp_cursor_position, i_rsp_scrolled}), "stalled response changed")

    // a scroll leaves the cursor at the last row start, plus one after a put
    `ASSERT_CLK(a_scroll_cursor, i_clk, i_rst_n, i_rsp_valid && i_rsp_scrolled |-> i_rsp_cursor_position == LAST_ROW || i_rsp_cursor_position == LAST_ROW + 1'b1, "bad cursor after scroll")

    // only reads return cell data, and reads never scroll
    `ASSERT_CLK(a_read_no_scroll, i_clk, i_rst_n, i_rsp_valid && (i_rsp_read_character != '0 || i_rsp_read_attribute != '0) |-> !i_rsp_scrolled, "read result marked scrolled")
endmodule

bind text_console_cursor_scroll_unit tccs_checker u_tccs_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_req_ready           (i_req.ready),
    .i_rsp_valid           (o_rsp.valid),
    .i_rsp_ready           (o_rsp.ready),
    .i_rsp_read_character  (o_rsp.read_character),
    .i_rsp_read_attribute  (o_rsp.read_attribute),
    .i_rsp_cursor_position (o_rsp.cursor_position),
    .i_rsp_scrolled        (o_rsp.scrolled)
);
